/* hdl/alumd_pkg.sv */
// shared types and constants for the integer alu
package alumd_pkg;

  localparam int unsigned XLEN       = 64;
  localparam int unsigned HLEN       = 32;
  localparam int unsigned DIV_STAGES = 64;

  typedef enum logic [3:0] {
    ACT_MUL = 4'd0,
    ACT_DIV = 4'd1,
    ACT_MOD = 4'd2,
    ACT_SHL = 4'd3,
    ACT_SHR = 4'd4,
    ACT_SAR = 4'd5,
    ACT_ADD = 4'd6,
    ACT_SUB = 4'd7,
    ACT_AND = 4'd8,
    ACT_XOR = 4'd9,
    ACT_OR  = 4'd10
  } action_t;

  // control and early result that travel beside the divider
  typedef struct packed {
    logic [3:0]      action;
    logic            is_signed;
    logic            wide;
    logic            err;
    logic            qneg;
    logic            rneg;
    logic [XLEN-1:0] res;
  } side_t;

endpackage

/* hdl/alumd_if.sv */
// request and result channel interfaces
interface alumd_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic        is_signed;
  logic        wide;
  logic [63:0] lhs;
  logic [63:0] rhs;
  modport source (output valid, action, is_signed, wide, lhs, rhs, input ready);
  modport sink (input valid, action, is_signed, wide, lhs, rhs, output ready);
endinterface

interface alumd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic        divide_error;
  modport source (output valid, result, divide_error, input ready);
  modport sink (input valid, result, divide_error, output ready);
endinterface

/* hdl/alumd_div.sv */
// pipelined restoring divider, one quotient bit per stage
module alumd_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [63:0]              dvd,
  input  logic [63:0]              dvs,
  input  alumd_pkg::side_t         side_in,
  output logic                     out_valid,
  output logic [63:0]              quo,
  output logic [63:0]              rem,
  output alumd_pkg::side_t         side_out
);

  localparam int unsigned N = alumd_pkg::DIV_STAGES;

  logic             valid_r [N];
  logic [63:0]      rem_r  [N];
  logic [63:0]      dq_r   [N];
  logic [63:0]      dvs_r  [N];
  alumd_pkg::side_t side_r [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [63:0]      prev_rem, prev_dq, prev_dvs;
    logic             prev_valid;
    alumd_pkg::side_t prev_side;
    logic [64:0]      shifted, diff;
    logic             ge;

    if (g == 0) begin : g_first
      assign prev_rem   = '0;
      assign prev_dq    = dvd;
      assign prev_dvs   = dvs;
      assign prev_valid = in_valid;
      assign prev_side  = side_in;
    end else begin : g_rest
      assign prev_rem   = rem_r[g-1];
      assign prev_dq    = dq_r[g-1];
      assign prev_dvs   = dvs_r[g-1];
      assign prev_valid = valid_r[g-1];
      assign prev_side  = side_r[g-1];
    end

    // trial subtract of the divisor from the shifted partial remainder
    assign shifted = {prev_rem, prev_dq[63]};
    assign diff    = shifted - {1'b0, prev_dvs};
    assign ge      = ~diff[64];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g] <= 1'b0;
      end else if (en) begin
        valid_r[g] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= ge ? diff[63:0] : shifted[63:0];
        dq_r[g]   <= {prev_dq[62:0], ge};
        dvs_r[g]  <= prev_dvs;
        side_r[g] <= prev_side;
      end
    end
  end

  assign out_valid = valid_r[N-1];
  assign quo       = dq_r[N-1];
  assign rem       = rem_r[N-1];
  assign side_out  = side_r[N-1];

endmodule

/* hdl/integer_alu_mul_div_shift_logic_unit.sv */
// top level of the pipelined 32/64-bit integer alu with multiply and divide
// Each request (action, is_signed, wide, lhs, rhs) gives one result and a
// divide_error flag, in request order. The unit is a fixed pipeline of 67
// stages: an operand stage that forms the extended operands, magnitudes,
// shift, add, subtract and logic results and three 32-bit partial products,
// a stage that sums the partial products into the low 64 bits of the
// product, 64 divider stages that each retire one quotient bit, and an
// output register that restores the signs and wraps the result to the
// selected width. A new request is taken every cycle; the whole pipeline
// holds while a result waits at the output. Narrow results are sign-extended
// when is_signed is set and zero-extended otherwise. Division by zero gives 0
// with divide_error set; the most negative value divided by -1 wraps; shift
// counts at or above the width give 0, or all sign bits for a signed right
// shift.
module integer_alu_mul_div_shift_logic_unit (
  input logic          clk,
  input logic          rst_n,
  alumd_in_if.sink     in_req,
  alumd_out_if.source  out_res
);

  logic en;

  // operand stage, combinational
  logic        sgn, wide;
  logic [63:0] a, b, ma, mb, sh_res, pre_res;
  logic [5:0]  cnt;
  logic        cnt_big, b_zero, a_neg, b_neg;
  logic [3:0]  act;

  assign act  = in_req.action;
  assign sgn  = in_req.is_signed;
  assign wide = in_req.wide;

  // extend narrow operands so that one 64-bit datapath serves both widths
  always_comb begin
    if (wide) begin
      a = in_req.lhs;
      b = in_req.rhs;
    end else if (sgn) begin
      a = {{32{in_req.lhs[31]}}, in_req.lhs[31:0]};
      b = {{32{in_req.rhs[31]}}, in_req.rhs[31:0]};
    end else begin
      a = {32'b0, in_req.lhs[31:0]};
      b = {32'b0, in_req.rhs[31:0]};
    end
  end

  assign a_neg  = sgn & a[63];
  assign b_neg  = sgn & b[63];
  assign ma     = a_neg ? (64'd0 - a) : a;
  assign mb     = b_neg ? (64'd0 - b) : b;
  assign b_zero = (b == 64'd0);

  // shift count is the raw pattern at the selected width, read unsigned
  assign cnt     = wide ? in_req.rhs[5:0] : {1'b0, in_req.rhs[4:0]};
  assign cnt_big = wide ? (|in_req.rhs[63:6]) : (|in_req.rhs[31:5]);

  always_comb begin
    sh_res = '0;
    case (act)
      alumd_pkg::ACT_SHL: sh_res = cnt_big ? 64'd0 : (a << cnt);
      default: begin
        if (sgn) begin
          sh_res = cnt_big ? {64{a[63]}} : 64'($signed(a) >>> cnt);
        end else begin
          sh_res = cnt_big ? 64'd0 : (a >> cnt);
        end
      end
    endcase
  end

  always_comb begin
    case (act)
      alumd_pkg::ACT_SHL, alumd_pkg::ACT_SHR,
      alumd_pkg::ACT_SAR: pre_res = sh_res;
      alumd_pkg::ACT_ADD: pre_res = a + b;
      alumd_pkg::ACT_SUB: pre_res = a - b;
      alumd_pkg::ACT_AND: pre_res = a & b;
      alumd_pkg::ACT_XOR: pre_res = a ^ b;
      alumd_pkg::ACT_OR:  pre_res = a | b;
      default:            pre_res = '0;
    endcase
  end

  // operand stage registers
  logic             s0_valid_r;
  alumd_pkg::side_t s0_side_r;
  logic [63:0]      s0_dvd_r, s0_dvs_r, s0_p0_r;
  logic [31:0]      s0_p1_r, s0_p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side_r.action    <= act;
      s0_side_r.is_signed <= sgn;
      s0_side_r.wide      <= wide;
      s0_side_r.err       <= b_zero & ((act == alumd_pkg::ACT_DIV) |
                                       (act == alumd_pkg::ACT_MOD));
      s0_side_r.qneg      <= a_neg ^ b_neg;
      s0_side_r.rneg      <= a_neg;
      s0_side_r.res       <= pre_res;
      s0_dvd_r            <= ma;
      s0_dvs_r            <= mb;
      // low 64 bits of the product from three 32-bit partial products
      s0_p0_r             <= 64'(a[31:0]) * 64'(b[31:0]);
      s0_p1_r             <= 32'(a[31:0] * b[63:32]);
      s0_p2_r             <= 32'(a[63:32] * b[31:0]);
    end
  end

  // product sum stage
  logic             s1_valid_r;
  alumd_pkg::side_t s1_side_r, s1_side_nxt;
  logic [63:0]      s1_dvd_r, s1_dvs_r;

  always_comb begin
    s1_side_nxt = s0_side_r;
    if (s0_side_r.action == alumd_pkg::ACT_MUL) begin
      s1_side_nxt.res = s0_p0_r + {s0_p1_r + s0_p2_r, 32'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r <= s1_side_nxt;
      s1_dvd_r  <= s0_dvd_r;
      s1_dvs_r  <= s0_dvs_r;
    end
  end

  // divider stages
  logic             dv_valid;
  logic [63:0]      dv_quo, dv_rem;
  alumd_pkg::side_t dv_side;

  alumd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s1_valid_r),
    .dvd       (s1_dvd_r),
    .dvs       (s1_dvs_r),
    .side_in   (s1_side_r),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .rem       (dv_rem),
    .side_out  (dv_side)
  );

  // sign restore, result select and width wrap
  logic [63:0] fin_raw, fin_res;

  always_comb begin
    case (dv_side.action)
      alumd_pkg::ACT_DIV: fin_raw = dv_side.qneg ? (64'd0 - dv_quo) : dv_quo;
      alumd_pkg::ACT_MOD: fin_raw = dv_side.rneg ? (64'd0 - dv_rem) : dv_rem;
      default:            fin_raw = dv_side.res;
    endcase
    if (dv_side.err) begin
      fin_raw = '0;
    end
    if (dv_side.wide) begin
      fin_res = fin_raw;
    end else if (dv_side.is_signed) begin
      fin_res = {{32{fin_raw[31]}}, fin_raw[31:0]};
    end else begin
      fin_res = {32'b0, fin_raw[31:0]};
    end
  end

  // output register
  logic        out_valid_r;
  logic [63:0] out_result_r;
  logic        out_err_r;
  logic        out_wide_r, out_sgn_r;

  assign en = ~out_valid_r | out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result_r <= fin_res;
      out_err_r    <= dv_side.err;
      out_wide_r   <= dv_side.wide;
      out_sgn_r    <= dv_side.is_signed;
    end
  end

  assign in_req.ready         = en;
  assign out_res.valid        = out_valid_r;
  assign out_res.result       = out_result_r;
  assign out_res.divide_error = out_err_r;

`ifndef NO_ASSERTIONS
  // a divide error always comes with a zero result
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_result_r == 64'd0)
    else $error("divide error with nonzero result");

  // narrow signed results are sign-extended
  a_narrow_sext: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_wide_r && out_sgn_r |->
      out_result_r[63:32] == {32{out_result_r[31]}})
    else $error("narrow signed result not sign-extended");

  // narrow unsigned results are zero-extended
  a_narrow_zext: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_wide_r && !out_sgn_r |-> out_result_r[63:32] == 32'd0)
    else $error("narrow unsigned result not zero-extended");

  // error flag only raised for divide or remainder
  a_err_op: assert property (@(posedge clk) disable iff (!rst_n)
    dv_valid && dv_side.err |->
      (dv_side.action == alumd_pkg::ACT_DIV) || (dv_side.action == alumd_pkg::ACT_MOD))
    else $error("divide error on non-divide action");
`endif

endmodule

/* test/tb.sv */
// self-checking testbench for the pipelined 32/64-bit integer alu
`timescale 1ns / 1ps

module tb;

  // action codes that the unit does not define; they must give 0 with no error
  localparam logic [3:0] ACT_UNDEF_LO = 4'd11;
  localparam logic [3:0] ACT_UNDEF_HI = 4'd15;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN64    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN32    = 64'h0000_0000_8000_0000;
  localparam logic [63:0] MAX32    = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] ONES32   = 64'h0000_0000_FFFF_FFFF;

  localparam int RANDOM_OPS  = 680;
  localparam int LONG_HOLD   = 1000; // receiver hold-off, long enough to fill the pipe
  localparam int DRAIN_WAIT  = 80;   // pipeline latency plus margin
  localparam int STALL_LIMIT = 4000; // cycles with no handshake on either side

  typedef struct {
    logic [3:0]  action;
    logic        is_signed;
    logic        wide;
    logic [63:0] lhs;
    logic [63:0] rhs;
  } alu_op_t;

  // one directed row: an operation and, where obvious, the result it must give
  typedef struct {
    alu_op_t     op;
    bit          typed;
    logic [63:0] result;
    logic        div_err;
  } dir_row_t;

  logic clk;
  logic rst_n;

  alumd_in_if  in_req ();
  alumd_out_if out_res ();

  integer_alu_mul_div_shift_logic_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  always #4 clk = ~clk;

  // expected results in request order, bit 64 is divide_error
  logic [64:0] pending_results[$];
  int  mismatch_cnt;
  bit  sender_idles;   // random gaps between requests
  bit  receiver_idles; // random stalls on the result side
  bit  long_hold_req;  // asks the receiver for one long hold-off
  dir_row_t dir_rows[$];

  // golden alu: returns {divide_error, result}
  function automatic logic [64:0] alu_compute(alu_op_t op);
    logic [63:0] mask, a, b, cnt, mag_a, mag_b, q, r;
    int unsigned width;
    logic err;
    mask  = op.wide ? ALL_ONES : ONES32;
    width = op.wide ? 64 : 32;
    a     = op.lhs & mask;
    b     = op.rhs & mask;
    cnt   = b;
    r     = '0;
    err   = 1'b0;
    // narrow signed operands are widened so one 64-bit path serves both widths
    if (op.is_signed && !op.wide) begin
      a = {{32{a[31]}}, a[31:0]};
      b = {{32{b[31]}}, b[31:0]};
    end
    mag_a = a[63] ? -a : a;
    mag_b = b[63] ? -b : b;
    case (op.action)
      alumd_pkg::ACT_MUL: r = a * b;
      alumd_pkg::ACT_DIV, alumd_pkg::ACT_MOD: begin
        if (cnt == '0) begin
          err = 1'b1;
        end else if (!op.is_signed) begin
          r = (op.action == alumd_pkg::ACT_DIV) ? a / b : a % b;
        end else if (op.action == alumd_pkg::ACT_DIV) begin
          // truncate toward zero; most negative by -1 wraps on its own here
          q = mag_a / mag_b;
          r = (a[63] != b[63]) ? -q : q;
        end else begin
          q = mag_a % mag_b;
          r = a[63] ? -q : q;
        end
      end
      alumd_pkg::ACT_SHL: r = (cnt >= width) ? '0 : a << cnt;
      alumd_pkg::ACT_SHR, alumd_pkg::ACT_SAR: begin
        if (!op.is_signed) r = (cnt >= width) ? '0 : a >> cnt;
        else if (cnt >= width) r = a[63] ? ALL_ONES : '0;
        else r = $signed(a) >>> cnt;
      end
      alumd_pkg::ACT_ADD: r = a + b;
      alumd_pkg::ACT_SUB: r = a - b;
      alumd_pkg::ACT_AND: r = a & b;
      alumd_pkg::ACT_XOR: r = a ^ b;
      alumd_pkg::ACT_OR:  r = a | b;
      default: r = '0;
    endcase
    r = r & mask;
    if (op.is_signed && !op.wide) r = {{32{r[31]}}, r[31:0]};
    return {err, r};
  endfunction

  function automatic alu_op_t make_op(logic [3:0] act, logic sgn, logic wd,
                                      logic [63:0] lhs, logic [63:0] rhs);
    alu_op_t op;
    op.action    = act;
    op.is_signed = sgn;
    op.wide      = wd;
    op.lhs       = lhs;
    op.rhs       = rhs;
    return op;
  endfunction

  function automatic void add_row(alu_op_t op, bit typed, logic [63:0] res, logic err);
    dir_row_t row;
    row.op      = op;
    row.typed   = typed;
    row.result  = res;
    row.div_err = err;
    dir_rows.push_back(row);
  endfunction

  // operand patterns lean on the corners where sign and width matter
  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = 64'd1;
      2: v = ALL_ONES;
      3: v = MIN64;
      4: v = MAX64;
      5: v = $urandom_range(0, 1) ? MIN32 : MAX32;
      6: v = {32'($urandom), 32'($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0)};
      default: v = {32'($urandom), 32'($urandom)};
    endcase
    return v;
  endfunction

  function automatic alu_op_t random_op();
    alu_op_t op;
    // mostly defined actions, now and then an undefined code
    op.action    = ($urandom_range(0, 19) == 0) ?
                   4'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI)) :
                   4'($urandom_range(alumd_pkg::ACT_MUL, alumd_pkg::ACT_OR));
    op.is_signed = 1'($urandom);
    op.wide      = 1'($urandom);
    op.lhs       = pick_operand();
    op.rhs       = pick_operand();
    // shifts: keep most counts inside the width so the shifter is exercised
    if (op.action inside {alumd_pkg::ACT_SHL, alumd_pkg::ACT_SHR, alumd_pkg::ACT_SAR} &&
        $urandom_range(0, 3) != 0)
      op.rhs = {32'($urandom) & {32{1'($urandom_range(0, 7) == 0)}},
                32'($urandom_range(0, 70))};
    // keep zero divisors from crowding out real divisions
    if (op.action inside {alumd_pkg::ACT_DIV, alumd_pkg::ACT_MOD} &&
        $urandom_range(0, 1) == 0)
      op.rhs = {32'($urandom), 32'($urandom_range(1, 200))};
    return op;
  endfunction

  // drives one request and returns at the edge where it is taken;
  // must be entered on a rising edge
  task automatic send_op(alu_op_t op, bit typed, logic [64:0] typed_exp);
    int gap;
    gap = sender_idles ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid     <= 1'b1;
    in_req.action    <= op.action;
    in_req.is_signed <= op.is_signed;
    in_req.wide      <= op.wide;
    in_req.lhs       <= op.lhs;
    in_req.rhs       <= op.rhs;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    pending_results.push_back(typed ? typed_exp : alu_compute(op));
  endtask

  // result side: checks every handshake and draws its own stalls
  initial begin
    int stall;
    logic [64:0] exp;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_res.valid && out_res.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: result=%h divide_error=%b",
                 out_res.result, out_res.divide_error);
          mismatch_cnt++;
        end else begin
          exp = pending_results.pop_front();
          if (out_res.result !== exp[63:0]) begin
            $error("result: expected %h, actual %h", exp[63:0], out_res.result);
            mismatch_cnt++;
          end
          if (out_res.divide_error !== exp[64]) begin
            $error("divide_error: expected %b, actual %b", exp[64], out_res.divide_error);
            mismatch_cnt++;
          end
        end
        stall = receiver_idles ? $urandom_range(0, 9) : 0;
      end
      if (long_hold_req) begin
        // one long hold-off so the pipe fills and backs up into the input
        out_res.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        out_res.ready <= 1'b1;
      end else if (stall > 0) begin
        out_res.ready <= 1'b0;
        stall--;
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  // watchdog: nothing moving on either side for too long ends the run
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [64:0] typed_exp;
    clk              = 1'b0;
    rst_n            = 1'b0;
    mismatch_cnt     = 0;
    sender_idles     = 1'b1;
    receiver_idles   = 1'b1;
    long_hold_req    = 1'b0;
    in_req.valid     = 1'b0;
    in_req.action    = alumd_pkg::ACT_ADD;
    in_req.is_signed = 1'b0;
    in_req.wide      = 1'b0;
    in_req.lhs       = '0;
    in_req.rhs       = '0;
    out_res.ready    = 1'b0;

    // directed corners; typed results where they are plain to see
    add_row(make_op(alumd_pkg::ACT_DIV, 1, 1, MAX64, '0), 1, '0, 1);   // divide by zero
    add_row(make_op(alumd_pkg::ACT_MOD, 0, 0, ONES32, 64'hFFFF_FFFF_0000_0000),
            1, '0, 1);                                                  // zero low word
    add_row(make_op(alumd_pkg::ACT_DIV, 1, 1, MIN64, ALL_ONES), 1, MIN64, 0); // min / -1
    add_row(make_op(alumd_pkg::ACT_MOD, 1, 1, MIN64, ALL_ONES), 1, '0, 0);
    add_row(make_op(alumd_pkg::ACT_DIV, 1, 0, MIN32, ONES32), 1, 64'hFFFF_FFFF_8000_0000, 0);
    add_row(make_op(alumd_pkg::ACT_DIV, 1, 1, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2),
            0, '0, 0);                                                  // -7/2
    add_row(make_op(alumd_pkg::ACT_MOD, 1, 0, 64'd7, 64'hFFFF_FFFE), 0, '0, 0); // 7 % -2
    add_row(make_op(alumd_pkg::ACT_DIV, 0, 1, ALL_ONES, 64'd3), 0, '0, 0);
    add_row(make_op(alumd_pkg::ACT_MUL, 0, 1, ALL_ONES, ALL_ONES), 1, 64'd1, 0);
    add_row(make_op(alumd_pkg::ACT_MUL, 1, 0, MAX32, MAX32), 0, '0, 0);
    add_row(make_op(alumd_pkg::ACT_SHL, 0, 1, ALL_ONES, 64'd64), 1, '0, 0); // count at width
    add_row(make_op(alumd_pkg::ACT_SHL, 1, 0, MAX32, 64'd1), 0, '0, 0);     // signed shl wraps
    add_row(make_op(alumd_pkg::ACT_SAR, 1, 1, MIN64, 64'd64), 1, ALL_ONES, 0); // sign bits
    add_row(make_op(alumd_pkg::ACT_SHR, 1, 0, MIN32, ONES32), 1, ALL_ONES, 0); // huge count
    add_row(make_op(alumd_pkg::ACT_SHR, 0, 1, ALL_ONES, ALL_ONES), 1, '0, 0);
    add_row(make_op(alumd_pkg::ACT_SAR, 0, 0, ONES32, 64'd4), 1, 64'h0FFF_FFFF, 0); // logical
    add_row(make_op(alumd_pkg::ACT_SHR, 1, 1, MIN64, 64'd63), 1, ALL_ONES, 0);
    add_row(make_op(alumd_pkg::ACT_ADD, 0, 1, ALL_ONES, 64'd1), 1, '0, 0);
    add_row(make_op(alumd_pkg::ACT_ADD, 1, 0, MAX32, 64'd1), 1, 64'hFFFF_FFFF_8000_0000, 0);
    add_row(make_op(alumd_pkg::ACT_SUB, 0, 0, '0, 64'd1), 1, ONES32, 0);
    add_row(make_op(alumd_pkg::ACT_AND, 1, 1, ALL_ONES, MIN64), 1, MIN64, 0);
    add_row(make_op(alumd_pkg::ACT_XOR, 0, 1, ALL_ONES, MAX64), 1, MIN64, 0);
    add_row(make_op(alumd_pkg::ACT_OR, 1, 0, MIN32, '0), 1, 64'hFFFF_FFFF_8000_0000, 0);
    add_row(make_op(ACT_UNDEF_LO, 1, 1, ALL_ONES, ALL_ONES), 1, '0, 0);
    add_row(make_op(ACT_UNDEF_HI, 0, 0, ALL_ONES, ALL_ONES), 1, '0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      typed_exp = {dir_rows[i].div_err, dir_rows[i].result};
      send_op(dir_rows[i].op, dir_rows[i].typed, typed_exp);
    end

    for (int n = 0; n < RANDOM_OPS; n++) begin
      // back-to-back stretch with no idling on either side
      sender_idles   = !(n >= 100 && n < 180);
      receiver_idles = !(n >= 100 && n < 180);
      // long receiver hold-off while requests keep coming
      if (n == 250) long_hold_req = 1'b1;
      // sender pause until everything in flight has come back
      if (n == 450) begin
        in_req.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_op(random_op(), 0, '0);
    end
    in_req.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
